@@ sv/assert_macros.svh @@
// Assertion macros shared by the conditioner modules.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/csc_pkg.sv @@
// Shared types and constants of the current sense conditioner.
// Used by the configuration, controller, datapath and top-level modules.
package csc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CODE_W = 16;
	localparam int ZERO_W = 15;
	localparam int GAIN_W = 24;
	localparam int ALPHA_W = 17;
	localparam int DB_W = 20;
	localparam int OUT_W = 21;
	localparam int ST_W = 40;
	localparam int IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ALPHA_SHIFT = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

	typedef enum logic [IDX_W-1:0] {
		REG_ZERO_CODE = 3'd0,
		REG_INVERT_SIGN = 3'd1,
		REG_GAIN_Q16 = 3'd2,
		REG_ALPHA_Q16 = 3'd3,
		REG_DEADBAND_MA = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ZERO_W-1:0] zero_code;
		logic invert_sign;
		logic [GAIN_W-1:0] gain_q16;
		logic [ALPHA_W-1:0] alpha_q16;
		logic [DB_W-1:0] deadband_ma;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_DIFF,
		ST_PMUL,
		ST_ACC,
		ST_UPD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic diff;
		logic pmul;
		logic acc;
		logic upd;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic primed;
	} status_t;

endpackage

@@ sv/csc_cfg.sv @@
// Configuration register file of the current sense conditioner.
// Depends on csc_pkg for the register index codes and the cfg_t bundle.
module csc_cfg import csc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_code <= '0;
			cfg_q.invert_sign <= 1'b0;
			cfg_q.gain_q16 <= GAIN_RESET;
			cfg_q.alpha_q16 <= ALPHA_ONE;
			cfg_q.deadband_ma <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ZERO_CODE: cfg_q.zero_code <= cfg_data[ZERO_W-1:0];
				REG_INVERT_SIGN: cfg_q.invert_sign <= cfg_data[0];
				REG_GAIN_Q16: cfg_q.gain_q16 <= cfg_data[GAIN_W-1:0];
				REG_ALPHA_Q16: cfg_q.alpha_q16 <= cfg_data[ALPHA_W-1:0];
				REG_DEADBAND_MA: cfg_q.deadband_ma <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/csc_ctrl.sv @@
// Sequencer of the current sense conditioner: walks one item through the datapath.
// Depends on csc_pkg (state_t, cmd_t, status_t) and assert_macros.svh.
`include "assert_macros.svh"

module csc_ctrl import csc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic result_valid_q;
	logic accept;
	logic out_free;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept = sample_valid && !sample_stall;
	// The output register can take a new item once the old one is gone or leaving.
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				// The first item after reset loads the filter and skips the update.
				state_d = status.primed ? ST_DIFF : ST_FIN;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.pmul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	`CSC_ASSERT(a_fin_needs_room, clk, arst_n, cmd.fin |-> out_free, "result overwritten")
	`CSC_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == ST_MUL, "item not started")
	`CSC_ASSERT(a_valid_from_fin, clk, arst_n, $rose(result_valid_q) |-> $past(cmd.fin), "stray result")

endmodule

@@ sv/csc_datapath.sv @@
// Arithmetic of the current sense conditioner: offset, gain, filter, deadband, output register.
// Depends on csc_pkg (cfg_t, cmd_t, status_t, widths) and assert_macros.svh.
`include "assert_macros.svh"

module csc_datapath import csc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  cfg_t                     cfg,
	input  logic signed [CODE_W-1:0] adc_code,
	output status_t                  status,
	output logic signed [OUT_W-1:0]  current_ma,
	output logic                     in_deadband
);

	localparam int SHL = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int PW = ST_W + SHL;
	localparam int DW = ST_W + 1;
	localparam int LO_W = 24;
	localparam int HI_W = DW - LO_W;
	localparam int PLO_W = ALPHA_W + LO_W;
	localparam int PHI_W = ALPHA_W + 1 + HI_W;
	localparam int ACC_W = PHI_W + LO_W;
	localparam int MW = (DB_W + FRAC_BITS > ST_W) ? DB_W + FRAC_BITS : ST_W;
	localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
	localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (ALPHA_SHIFT - 1);
	localparam logic signed [DW-1:0] OUT_HALF = DW'(1) << (FRAC_BITS - 1);

	logic signed [CODE_W-1:0] diff_q;
	logic signed [ST_W-1:0] prod_q;
	logic signed [ST_W-1:0] samp_q;
	logic signed [DW-1:0] delta_q;
	logic [PLO_W-1:0] pp_lo_q;
	logic signed [PHI_W-1:0] pp_hi_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ST_W-1:0] filt_q;
	logic primed_q;
	logic signed [OUT_W-1:0] current_q;
	logic dead_q;

	logic [ZERO_W-1:0] code_clamp;
	logic signed [CODE_W-1:0] diff_c;
	logic signed [ST_W-1:0] prod_c;
	logic signed [ST_W-1:0] signed_c;
	logic signed [PW-1:0] ext_c;
	logic signed [PW-1:0] shifted_c;
	logic [PW-ST_W:0] top_c;
	logic signed [ST_W-1:0] samp_c;
	logic [ALPHA_W-1:0] alpha_c;
	logic signed [DW-1:0] filt_new_c;
	logic [ST_W-1:0] mag_c;
	logic [MW-1:0] thr_c;
	logic dead_c;
	logic signed [DW-1:0] rnd_c;
	logic [DW-OUT_W:0] rtop_c;
	logic signed [OUT_W-1:0] current_c;

	always_comb begin
		// Negative converter codes read as zero.
		code_clamp = adc_code[CODE_W-1] ? '0 : adc_code[ZERO_W-1:0];
		diff_c = $signed({1'b0, code_clamp}) - $signed({1'b0, cfg.zero_code});

		prod_c = ST_W'(diff_q) * ST_W'($signed({1'b0, cfg.gain_q16}));

		// Apply the optional sign inversion, rescale from Q16 to the internal fraction, then saturate to the state width.
		signed_c = cfg.invert_sign ? -prod_q : prod_q;
		ext_c = PW'(signed_c);
		shifted_c = (ext_c <<< SHL) >>> SHR;
		top_c = shifted_c[PW-1:ST_W-1];
		if ((&top_c) || !(|top_c)) begin
			samp_c = shifted_c[ST_W-1:0];
		end else begin
			samp_c = shifted_c[PW-1] ? ST_MIN : ST_MAX;
		end

		alpha_c = (cfg.alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q16;

		// The weighted sum lies between the old value and the sample, so it cannot overflow.
		filt_new_c = DW'(filt_q) + DW'(acc_q >>> ALPHA_SHIFT);

		mag_c = filt_q[ST_W-1] ? ST_W'(-filt_q) : ST_W'(filt_q);
		thr_c = MW'(cfg.deadband_ma) << FRAC_BITS;
		dead_c = MW'(mag_c) < thr_c;

		rnd_c = (DW'(filt_q) + OUT_HALF) >>> FRAC_BITS;
		rtop_c = rnd_c[DW-1:OUT_W-1];
		if (dead_c) begin
			current_c = '0;
		end else if ((&rtop_c) || !(|rtop_c)) begin
			current_c = rnd_c[OUT_W-1:0];
		end else begin
			current_c = rnd_c[DW-1] ? OUT_MIN : OUT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q <= diff_c;
		end
		if (cmd.mul) begin
			prod_q <= prod_c;
		end
		if (cmd.scale) begin
			samp_q <= samp_c;
		end
		if (cmd.diff) begin
			delta_q <= DW'(samp_q) - DW'(filt_q);
		end
		// The filter product is split into two narrow products over the delta's low and high parts.
		if (cmd.pmul) begin
			pp_lo_q <= PLO_W'(alpha_c) * PLO_W'(delta_q[LO_W-1:0]);
			pp_hi_q <= PHI_W'($signed({1'b0, alpha_c})) * PHI_W'($signed(delta_q[DW-1:LO_W]));
		end
		if (cmd.acc) begin
			acc_q <= (ACC_W'(pp_hi_q) <<< LO_W) + $signed(ACC_W'(pp_lo_q)) + ACC_HALF;
		end
		if (cmd.scale && !primed_q) begin
			filt_q <= samp_c;
		end else if (cmd.upd) begin
			filt_q <= filt_new_c[ST_W-1:0];
		end
		if (cmd.fin) begin
			current_q <= current_c;
			dead_q <= dead_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (cmd.scale) begin
			primed_q <= 1'b1;
		end
	end

	assign status.primed = primed_q;
	assign current_ma = current_q;
	assign in_deadband = dead_q;

	`CSC_ASSERT_NEXT(a_primed_sticks, clk, arst_n, primed_q, primed_q, "filter lost its primed state")
	`CSC_ASSERT(a_update_needs_prime, clk, arst_n, cmd.diff |-> primed_q, "update before first sample")

endmodule

@@ sv/current_sense_conditioner.sv @@
// Current sense conditioner, top level: offset, gain, exponential moving-average filter, deadband.
// The sequencer walks one item at a time through a single filter multiply pair and takes
// a new sample only while idle. Steps: load, multiply, scale, difference, filter multiply,
// accumulate, update, finish; the first item after reset skips from scale to finish.
// Reset (arst_n, asynchronous) restores the register defaults and unprimes the filter.
// Depends on csc_pkg, csc_cfg, csc_ctrl and csc_datapath.
module current_sense_conditioner import csc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic signed [CODE_W-1:0] adc_code,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [OUT_W-1:0]  current_ma,
	output logic                     in_deadband,
	input  logic                     cfg_write_en,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	status_t status;

	csc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	csc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	csc_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.adc_code    (adc_code),
		.status      (status),
		.current_ma  (current_ma),
		.in_deadband (in_deadband)
	);

endmodule
